>>> hdl/vertex_tuple_dedup_table_top_defines.svh
// assertion helpers for the tuple table
`ifndef VERTEX_TUPLE_DEDUP_TABLE_TOP_DEFINES_SVH
`define VERTEX_TUPLE_DEDUP_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define VTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/vtd_pkg.sv
package vtd_pkg;

  localparam int unsigned REF_W   = 16;
  localparam int unsigned KEY_W   = 4 * REF_W;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned OUT_DW  = 24;
  localparam int unsigned OUT_UW  = 2;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } vtd_state_e;

  typedef struct packed {
    logic [CNT_W-1:0]  entry_count;
    logic              full_res;
    logic              is_new;
    logic [SLOT_W-1:0] slot;
  } res_t;

  typedef struct packed {
    logic vld;
    res_t res;
  } res_beat_t;

endpackage

>>> hdl/vtd_store.sv
module vtd_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    wr_en_i,
  input  logic [AW-1:0]           wr_addr_i,
  input  logic [vtd_pkg::KEY_W-1:0] wr_data_i,
  input  logic                    rd_en_i,
  input  logic [AW-1:0]           rd_addr_i,
  output logic [vtd_pkg::KEY_W-1:0] rd_data_o
);
  import vtd_pkg::*;

  logic [KEY_W-1:0] mem_q [DEPTH];
  logic [KEY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/vtd_out_reg.sv
module vtd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vtd_pkg::res_beat_t beat_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               ready_i,
  output vtd_pkg::res_t      res_o
);
  import vtd_pkg::*;

  logic vld_q, vld_d;
  res_t res_q, res_d;

  always_comb begin
    ready_o = !vld_q || ready_i;
    vld_d   = vld_q;
    res_d   = res_q;
    if (ready_o) begin
      vld_d = beat_i.vld;
      if (beat_i.vld) begin
        res_d = beat_i.res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

>>> hdl/vtd_ctrl.sv
module vtd_ctrl #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      in_kind_i,
  input  logic [vtd_pkg::KEY_W-1:0] in_key_i,
  output logic                      rd_en_o,
  output logic [AW-1:0]             rd_addr_o,
  input  logic [vtd_pkg::KEY_W-1:0] rd_data_i,
  output logic                      wr_en_o,
  output logic [AW-1:0]             wr_addr_o,
  output logic [vtd_pkg::KEY_W-1:0] wr_data_o,
  output vtd_pkg::res_beat_t        beat_o,
  input  logic                      beat_ready_i
);
  import vtd_pkg::*;

  vtd_state_e       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [AW-1:0]    rd_idx_q, rd_idx_d;
  logic [AW-1:0]    cmp_idx_q, cmp_idx_d;
  res_t             res_q, res_d;

  logic        hit;
  logic        last;
  logic        table_full;
  logic [31:0] hit_slot_w;
  logic [31:0] new_slot_w;
  logic [31:0] cnt_w;
  logic [31:0] cnt_inc_w;

  assign hit_slot_w = 32'(cmp_idx_q);
  assign new_slot_w = 32'(count_q);
  assign cnt_w      = 32'(count_q);
  assign cnt_inc_w  = 32'(count_q) + 32'd1;
  assign hit        = (rd_data_i == key_q);
  assign last       = ((CW'(cmp_idx_q) + CW'(1)) == count_q);
  assign table_full = (count_q == CW'(DEPTH));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    key_d      = key_q;
    rd_idx_d   = rd_idx_q;
    cmp_idx_d  = cmp_idx_q;
    res_d      = res_q;
    in_ready_o = 1'b0;
    rd_en_o    = 1'b0;
    rd_addr_o  = rd_idx_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = count_q[AW-1:0];
    wr_data_o  = key_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          key_d = in_key_i;
          if (in_kind_i == KIND_CLEAR) begin
            count_d = '0;
            res_d   = '0;
            state_d = ST_DONE;
          end else begin
            // first read goes out with the accept
            rd_en_o   = 1'b1;
            rd_addr_o = '0;
            rd_idx_d  = AW'(1);
            cmp_idx_d = '0;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (count_q != '0 && hit) begin
          res_d.slot        = hit_slot_w[SLOT_W-1:0];
          res_d.is_new      = 1'b0;
          res_d.full_res    = 1'b0;
          res_d.entry_count = cnt_w[CNT_W-1:0];
          state_d           = ST_DONE;
        end else if (count_q == '0 || last) begin
          state_d = ST_DONE;
          if (table_full) begin
            res_d.slot        = '0;
            res_d.is_new      = 1'b0;
            res_d.full_res    = 1'b1;
            res_d.entry_count = cnt_w[CNT_W-1:0];
          end else begin
            wr_en_o           = 1'b1;
            count_d           = count_q + CW'(1);
            res_d.slot        = new_slot_w[SLOT_W-1:0];
            res_d.is_new      = 1'b1;
            res_d.full_res    = 1'b0;
            res_d.entry_count = cnt_inc_w[CNT_W-1:0];
          end
        end else begin
          // one entry per cycle; the compare works on the registered read data
          rd_en_o   = 1'b1;
          rd_idx_d  = rd_idx_q + AW'(1);
          cmp_idx_d = rd_idx_q;
        end
      end
      ST_DONE: begin
        if (beat_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign beat_o.vld = (state_q == ST_DONE);
  assign beat_o.res = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
  end

endmodule

>>> hdl/vertex_tuple_dedup_table_top.sv
// vertex tuple find-or-insert table
//
// s_axis carries one tuple per beat: tuser selects lookup (0) or clear (1),
// tdata holds the position, normal, tangent and texcoord refs. m_axis returns
// one beat per input beat, in order: the slot of the first stored tuple that
// matches, or the slot where an unmatched tuple was appended, with the flags
// is_new and full_res in tuser and the entry count after the beat.
// The stored tuples sit in one single-port-read memory of TABLE_DEPTH words;
// a lookup walks the stored entries one per cycle. A new beat is accepted
// in the cycle after the previous result has moved into the output register.
// Reset empties the table at once (only the entry count is cleared, no
// sweep of the memory). When m_axis stalls, one result waits in the output
// register while the next beat is processed; a second result then holds in
// the controller and s_axis stays not ready until the output drains.
`include "vertex_tuple_dedup_table_top_defines.svh"

module vertex_tuple_dedup_table_top #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // position_ref, normal_ref, tangent_ref, texcoord_ref
  input  logic [vtd_pkg::KEY_W-1:0]  s_axis_tdata,
  // kind
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // slot, entry_count, zero pad
  output logic [vtd_pkg::OUT_DW-1:0] m_axis_tdata,
  // is_new, full_res
  output logic [vtd_pkg::OUT_UW-1:0] m_axis_tuser
);
  import vtd_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic [KEY_W-1:0] in_key;
  res_beat_t        beat;
  logic             beat_ready;
  res_t             out_res;

  // internal key order: position high down to texcoord low
  assign in_key = {s_axis_tdata[REF_W-1:0], s_axis_tdata[2*REF_W-1:REF_W],
                   s_axis_tdata[3*REF_W-1:2*REF_W], s_axis_tdata[4*REF_W-1:3*REF_W]};

  vtd_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_kind_i    (s_axis_tuser),
    .in_key_i     (in_key),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .beat_o       (beat),
    .beat_ready_i (beat_ready)
  );

  vtd_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  vtd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat),
    .ready_o (beat_ready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {(OUT_DW - SLOT_W - CNT_W)'(0), out_res.entry_count, out_res.slot};
  assign m_axis_tuser = {out_res.full_res, out_res.is_new};

  `VTD_ASSERT_NOW(a_new_slot_count, m_axis_tvalid && out_res.is_new,
    out_res.entry_count[SLOT_W-1:0] == out_res.slot + SLOT_W'(1),
    "appended slot does not match entry count")
  `VTD_ASSERT_NOW(a_full_result, m_axis_tvalid && out_res.full_res,
    out_res.slot == '0 && !out_res.is_new, "full result carries a slot")
  `VTD_ASSERT_NOW(a_no_accept_pending, beat.vld, !s_axis_tready,
    "input taken while a result is pending")
  `VTD_ASSERT_NEXT(a_pending_moves, beat.vld && beat_ready,
    m_axis_tvalid, "pending result not moved to output")

endmodule
